/* rtl/tti_pkg.sv */
// Package: shared types and constants of the trajectory time interpolator.
`default_nettype none
package tti_pkg;
  localparam int unsigned NUM_FIELDS = 9;
  localparam int unsigned FIELD_W    = 32;

  // Field positions inside one stored row
  localparam int unsigned FLD_TIME = 0;
  localparam int unsigned FLD_DIST = 6;
  localparam int unsigned FLD_LAST = 8;

  // Input item kinds
  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_LOAD  = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  typedef logic [NUM_FIELDS-1:0][FIELD_W-1:0] row_t;
endpackage
`default_nettype wire

/* rtl/tti_if.sv */
// Interfaces: input item channel and result channel.
`default_nettype none
interface tti_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  kind;
  logic signed [31:0] sample_time;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] heading;
  logic signed [31:0] curvature;
  logic signed [31:0] steer;
  logic signed [31:0] arc_length;
  logic signed [31:0] speed;
  logic signed [31:0] accel;
  modport source (output valid, kind, sample_time, pos_x, pos_y, heading, curvature,
                  steer, arc_length, speed, accel, input ready);
  modport sink (input valid, kind, sample_time, pos_x, pos_y, heading, curvature,
                steer, arc_length, speed, accel, output ready);
endinterface

interface tti_out_if;
  logic               valid;
  logic               ready;
  logic               found;
  logic signed [31:0] out_time;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_heading;
  logic signed [31:0] out_curvature;
  logic signed [31:0] out_steer;
  logic signed [31:0] out_arc_length;
  logic signed [31:0] out_speed;
  logic signed [31:0] out_accel;
  modport source (output valid, found, out_time, out_x, out_y, out_heading, out_curvature,
                  out_steer, out_arc_length, out_speed, out_accel, input ready);
  modport sink (input valid, found, out_time, out_x, out_y, out_heading, out_curvature,
                out_steer, out_arc_length, out_speed, out_accel, output ready);
endinterface
`default_nettype wire

/* rtl/trajectory_time_interpolator_top.sv */
// Top level: load/clear/query sequencer around the point store, divider and lerp unit.
// Clear and load complete in the idle state. A query runs store reads for the bounds check and
// binary search, then, when it falls between two points, the divider for alpha (only if
// 0 < num < den) and a multiply/add pair for each of the eight fields, and last loads the
// output register.
// The result sits in an output register; a new item is taken once it is loaded there.
// Synchronous reset empties the store (count and base) and zeroes the drop time register.
`default_nettype none
module trajectory_time_interpolator_top #(
  parameter int unsigned DEPTH     = 64,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data,
  tti_in_if.sink           in_ch,
  tti_out_if.source        out_ch
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = AW + 1;
  localparam int unsigned ALW = FRAC_BITS + 1;
  localparam int unsigned PW = 33 + ALW;

  typedef enum logic [3:0] {
    S_IDLE, S_CHK0, S_CHKN, S_SRD, S_SCMP, S_FIN, S_PUT, S_R1, S_R0,
    S_DIV, S_LMUL, S_LADD, S_EMIT
  } state_t;

  state_t             state;
  logic signed [31:0] drop_time;
  logic [CW-1:0]      point_count;
  logic               base_taken;
  logic signed [31:0] base_time;
  logic signed [31:0] base_distance;
  logic signed [31:0] qtime;
  logic [CW-1:0]      lo;
  logic [CW-1:0]      hi;
  tti_pkg::row_t      row0;
  tti_pkg::row_t      row1;
  tti_pkg::row_t      res;
  logic               res_found;
  logic [ALW-1:0]     alpha;
  logic signed [PW-1:0] prod;
  logic [3:0]         fld;
  logic               out_valid;
  tti_pkg::row_t      out_row;
  logic               out_found;

  // store ports
  logic               wr_en;
  tti_pkg::row_t      wr_row;
  logic [AW-1:0]      rd_addr;
  tti_pkg::row_t      rd_row;

  // divider ports
  logic [32:0]        div_num;
  logic [32:0]        div_den;
  logic               div_done;
  logic [FRAC_BITS-1:0] div_quot;

  logic               accept;
  logic [CW:0]        mid_sum;
  logic [CW-1:0]      mid;
  logic signed [32:0] num_s;
  logic signed [32:0] den_s;
  logic signed [31:0] eff_btime;
  logic signed [31:0] eff_bdist;
  logic signed [32:0] t_diff;
  logic signed [32:0] d_diff;
  logic               keep;
  logic signed [32:0] lerp_diff;
  logic signed [PW-1:0] lerp_shift;

  assign in_ch.ready = (state == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign mid_sum     = {1'b0, lo} + {1'b0, hi};
  assign mid         = mid_sum[CW:1];

  // load path: base selection and saturating subtract
  assign keep      = base_taken || (in_ch.sample_time >= drop_time);
  assign eff_btime = base_taken ? base_time : in_ch.sample_time;
  assign eff_bdist = base_taken ? base_distance : in_ch.arc_length;
  assign t_diff    = {in_ch.sample_time[31], in_ch.sample_time} - {eff_btime[31], eff_btime};
  assign d_diff    = {in_ch.arc_length[31], in_ch.arc_length} - {eff_bdist[31], eff_bdist};

  function automatic logic [31:0] sat33(input logic signed [32:0] v);
    if (v[32] != v[31]) begin
      return v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return v[31:0];
  endfunction

  always_comb begin
    wr_row = '0;
    wr_row[tti_pkg::FLD_TIME] = sat33(t_diff);
    wr_row[1] = in_ch.pos_x;
    wr_row[2] = in_ch.pos_y;
    wr_row[3] = in_ch.heading;
    wr_row[4] = in_ch.curvature;
    wr_row[5] = in_ch.steer;
    wr_row[tti_pkg::FLD_DIST] = sat33(d_diff);
    wr_row[7] = in_ch.speed;
    wr_row[tti_pkg::FLD_LAST] = in_ch.accel;
  end

  assign wr_en = accept && (in_ch.kind == tti_pkg::KIND_LOAD) && keep &&
                 (point_count < CW'(DEPTH));

  // read address for the next cycle's data
  always_comb begin
    rd_addr = '0;
    unique case (state)
      S_CHK0: rd_addr = AW'(point_count - 1'b1);
      S_SRD:  rd_addr = mid[AW-1:0];
      S_FIN: begin
        if (lo >= point_count) begin
          rd_addr = AW'(point_count - 1'b1);
        end else begin
          rd_addr = lo[AW-1:0];
        end
      end
      S_R1:   rd_addr = AW'(lo - 1'b1);
      default: rd_addr = '0;
    endcase
  end

  // alpha operands
  assign num_s     = {qtime[31], qtime} - {row0[0][31], row0[0]};
  assign den_s     = {row1[0][31], row1[0]} - {row0[0][31], row0[0]};
  assign div_num   = num_s;
  assign div_den   = den_s;

  assign lerp_diff  = {row1[fld][31], row1[fld]} - {row0[fld][31], row0[fld]};
  assign lerp_shift = prod >>> FRAC_BITS;

  tti_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (point_count[AW-1:0]),
    .wr_data (wr_row),
    .rd_addr (rd_addr),
    .rd_data (rd_row)
  );

  logic div_go;

  tti_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_go),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // divider runs only for 0 < num < den
  assign div_go = (state == S_DIV) && (fld == 4'd0) && !(den_s <= 0 || num_s <= 0) &&
                  (num_s < den_s);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      drop_time     <= '0;
      point_count   <= '0;
      base_taken    <= 1'b0;
      base_time     <= '0;
      base_distance <= '0;
      out_valid     <= 1'b0;
      fld           <= '0;
    end else begin
      if (cfg_wr_en) begin
        drop_time <= cfg_wr_data;
      end
      if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            qtime <= in_ch.sample_time;
            case (in_ch.kind)
              tti_pkg::KIND_CLEAR: begin
                point_count   <= '0;
                base_taken    <= 1'b0;
                base_time     <= '0;
                base_distance <= '0;
              end
              tti_pkg::KIND_LOAD: begin
                if (!base_taken && keep) begin
                  base_taken    <= 1'b1;
                  base_time     <= in_ch.sample_time;
                  base_distance <= in_ch.arc_length;
                end
                if (wr_en) begin
                  point_count <= point_count + 1'b1;
                end
              end
              tti_pkg::KIND_QUERY: begin
                res       <= '0;
                res_found <= 1'b0;
                if (point_count < CW'(2)) begin
                  state <= S_EMIT;
                end else begin
                  state <= S_CHK0;
                end
              end
              default: ;
            endcase
          end
        end
        S_CHK0: begin
          if (qtime < $signed(rd_row[0])) begin
            state <= S_EMIT;
          end else begin
            state <= S_CHKN;
          end
        end
        S_CHKN: begin
          if (qtime > $signed(rd_row[0])) begin
            state <= S_EMIT;
          end else begin
            lo    <= '0;
            hi    <= point_count;
            state <= S_SRD;
          end
        end
        S_SRD: begin
          state <= (lo < hi) ? S_SCMP : S_FIN;
        end
        S_SCMP: begin
          if ($signed(rd_row[0]) < qtime) begin
            lo <= mid + 1'b1;
          end else begin
            hi <= mid;
          end
          state <= S_SRD;
        end
        S_FIN: begin
          if (lo >= point_count || lo == '0) begin
            state <= S_PUT;
          end else begin
            state <= S_R1;
          end
        end
        S_PUT: begin
          res       <= rd_row;
          res_found <= 1'b1;
          state     <= S_EMIT;
        end
        S_R1: begin
          row1  <= rd_row;
          state <= S_R0;
        end
        S_R0: begin
          row0  <= rd_row;
          fld   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          // fld doubles as a started flag while waiting on the divider
          if (den_s <= 0 || num_s <= 0) begin
            alpha <= '0;
            fld   <= 4'd1;
            state <= S_LMUL;
          end else if (num_s >= den_s) begin
            alpha <= ALW'(1) << FRAC_BITS;
            fld   <= 4'd1;
            state <= S_LMUL;
          end else if (fld == 4'd0) begin
            fld <= 4'd15;
          end else if (div_done) begin
            alpha <= {1'b0, div_quot};
            fld   <= 4'd1;
            state <= S_LMUL;
          end
        end
        S_LMUL: begin
          prod  <= PW'(lerp_diff) * $signed({1'b0, alpha});
          state <= S_LADD;
        end
        S_LADD: begin
          res[fld] <= row0[fld] + lerp_shift[31:0];
          if (fld == 4'(tti_pkg::FLD_LAST)) begin
            res[tti_pkg::FLD_TIME] <= qtime;
            res_found <= 1'b1;
            state     <= S_EMIT;
          end else begin
            fld   <= fld + 1'b1;
            state <= S_LMUL;
          end
        end
        S_EMIT: begin
          if (!out_valid || out_ch.ready) begin
            out_valid <= 1'b1;
            out_row   <= res;
            out_found <= res_found;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.found          = out_found;
  assign out_ch.out_time       = out_row[0];
  assign out_ch.out_x          = out_row[1];
  assign out_ch.out_y          = out_row[2];
  assign out_ch.out_heading    = out_row[3];
  assign out_ch.out_curvature  = out_row[4];
  assign out_ch.out_steer      = out_row[5];
  assign out_ch.out_arc_length = out_row[6];
  assign out_ch.out_speed      = out_row[7];
  assign out_ch.out_accel      = out_row[8];
endmodule
`default_nettype wire

/* rtl/tti_mem.sv */
// Point store: one write port, one registered read port.
`default_nettype none
module tti_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire tti_pkg::row_t wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output tti_pkg::row_t      rd_data
);
  tti_pkg::row_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

/* rtl/tti_div.sv */
// Restoring divider for alpha: quotient of (num << F) / den, num < den, one bit a cycle.
`default_nettype none
module tti_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [32:0]          num,
  input  wire logic [32:0]          den,
  output logic                      done,
  output logic      [FRAC_BITS-1:0] quot
);
  localparam int unsigned CW = $clog2(FRAC_BITS + 1);

  logic [33:0]   rem;
  logic [32:0]   dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [33:0]   shifted;

  assign shifted = {rem[32:0], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= {1'b0, num};
        dvs  <= den;
        cnt  <= CW'(FRAC_BITS);
        busy <= 1'b1;
      end else if (busy) begin
        // one quotient bit per cycle
        if (shifted >= {1'b0, dvs}) begin
          rem  <= shifted - {1'b0, dvs};
          quot <= {quot[FRAC_BITS-2:0], 1'b1};
        end else begin
          rem  <= shifted;
          quot <= {quot[FRAC_BITS-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

/* tb/sv/tb_trajectory_time_interpolator_top.sv */
// Testbench: drives load/clear/query transfers into the trajectory interpolator and checks results.
module tb_trajectory_time_interpolator_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 64;
  localparam int FRAC = 16;
  localparam int IDLE_LIMIT = 20000;
  localparam logic [1:0] KIND_NOP = 2'd3;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] t;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] hdg;
    logic signed [31:0] curv;
    logic signed [31:0] steer;
    logic signed [31:0] arc;
    logic signed [31:0] spd;
    logic signed [31:0] acc;
  } point_item_t;

  typedef struct packed {
    logic               found;
    logic signed [31:0] t;
    logic signed [31:0] f1, f2, f3, f4, f5, f6, f7, f8;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;

  tti_in_if in_ch ();
  tti_out_if out_ch ();

  trajectory_time_interpolator_top dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor state
  logic signed [31:0] m_shift = '0;
  logic signed [31:0] m_col [9][DEPTH];
  int                 m_count = 0;
  bit                 m_based = 0;
  logic signed [31:0] m_base_t = '0, m_base_d = '0;

  point_item_t pending_items[$];
  answer_t     expected_answers[$];
  int errors = 0;
  int n_queries = 0, n_found = 0, n_loads = 0;
  bit drive_hold = 0;
  bit sink_hold = 0;
  int long_stall = 0;

  function automatic logic signed [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] field_of(point_item_t it, int f);
    case (f)
      0: return it.t;
      1: return it.x;
      2: return it.y;
      3: return it.hdg;
      4: return it.curv;
      5: return it.steer;
      6: return it.arc;
      7: return it.spd;
      default: return it.acc;
    endcase
  endfunction

  function automatic answer_t pack_answer(logic found, logic signed [31:0] v[9]);
    answer_t a;
    a.found = found;
    a.t = v[0]; a.f1 = v[1]; a.f2 = v[2]; a.f3 = v[3]; a.f4 = v[4];
    a.f5 = v[5]; a.f6 = v[6]; a.f7 = v[7]; a.f8 = v[8];
    return a;
  endfunction

  // Expected answer for one query time
  function automatic answer_t lookup_point(logic signed [31:0] qt);
    logic signed [31:0] v[9];
    int lo, hi, mid, f;
    longint t0, t1, num, den, alpha, a, b, prod, r;
    for (f = 0; f < 9; f++) v[f] = '0;
    if (m_count < 2) return pack_answer(1'b0, v);
    if (qt > m_col[0][m_count-1] || qt < m_col[0][0]) return pack_answer(1'b0, v);
    lo = 0; hi = m_count;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (m_col[0][mid] < qt) lo = mid + 1; else hi = mid;
    end
    if (lo >= m_count || lo == 0) begin
      mid = (lo >= m_count) ? m_count - 1 : 0;
      for (f = 0; f < 9; f++) v[f] = m_col[f][mid];
      return pack_answer(1'b1, v);
    end
    t0 = m_col[0][lo-1]; t1 = m_col[0][lo];
    num = longint'(qt) - t0; den = t1 - t0;
    if (den <= 0 || num <= 0) alpha = 0;
    else if (num >= den) alpha = 1 << FRAC;
    else alpha = (num <<< FRAC) / den;
    v[0] = qt;
    for (f = 1; f < 9; f++) begin
      a = m_col[f][lo-1]; b = m_col[f][lo];
      prod = (b - a) * alpha;
      r = a + (prod >>> FRAC);
      v[f] = r[31:0];
    end
    return pack_answer(1'b1, v);
  endfunction

  // Apply one accepted transfer to the predictor
  task automatic track_item(point_item_t it);
    int f;
    longint tv;
    case (it.kind)
      tti_pkg::KIND_CLEAR: begin
        m_count = 0; m_based = 0; m_base_t = '0; m_base_d = '0;
      end
      tti_pkg::KIND_LOAD: begin
        n_loads++;
        if (!m_based) begin
          if (it.t < m_shift) return;
          m_based = 1; m_base_t = it.t; m_base_d = it.arc;
        end
        if (m_count >= DEPTH) return;
        for (f = 0; f < 9; f++) begin
          tv = longint'(field_of(it, f));
          if (f == tti_pkg::FLD_TIME) tv -= longint'(m_base_t);
          if (f == tti_pkg::FLD_DIST) tv -= longint'(m_base_d);
          m_col[f][m_count] = sat32(tv);
        end
        m_count++;
      end
      tti_pkg::KIND_QUERY: begin
        expected_answers.push_back(lookup_point(it.t));
        n_queries++;
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp);
    errors++;
    $display("mismatch %s: got %h expected %h (query %0d)", what, got, exp, n_queries);
  endtask

  // driver
  int gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.kind <= '0; in_ch.sample_time <= '0; in_ch.pos_x <= '0; in_ch.pos_y <= '0;
      in_ch.heading <= '0; in_ch.curvature <= '0; in_ch.steer <= '0;
      in_ch.arc_length <= '0; in_ch.speed <= '0; in_ch.accel <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) track_item(point_item_t'({in_ch.kind, in_ch.sample_time,
          in_ch.pos_x, in_ch.pos_y, in_ch.heading, in_ch.curvature, in_ch.steer,
          in_ch.arc_length, in_ch.speed, in_ch.accel}));
      if (in_ch.valid && !in_ch.ready) begin
        // keep offering the same item
      end else if (gap > 0) begin
        gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_items.size() > 0 && !drive_hold) begin
        point_item_t it;
        it = pending_items.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.kind <= it.kind; in_ch.sample_time <= it.t;
        in_ch.pos_x <= it.x; in_ch.pos_y <= it.y; in_ch.heading <= it.hdg;
        in_ch.curvature <= it.curv; in_ch.steer <= it.steer; in_ch.arc_length <= it.arc;
        in_ch.speed <= it.spd; in_ch.accel <= it.acc;
        gap = ($urandom_range(0, 3) == 0) ? (($urandom_range(0, 19) == 0) ?
              $urandom_range(20, 80) : $urandom_range(1, 4)) : 0;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: random ready, plus an occasional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (long_stall > 0) begin
      long_stall--;
      out_ch.ready <= 1'b0;
    end else if (sink_hold) begin
      long_stall = 400;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 0);
    end
  end

  // monitor
  int idle_cycles = 0;
  always @(posedge clk) begin
    answer_t e;
    if (!rst) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_answers.size() == 0) begin
          report_mismatch("unexpected result", {31'b0, out_ch.found}, '0);
        end else begin
          e = expected_answers.pop_front();
          if (e.found) n_found++;
          if (out_ch.found !== e.found) report_mismatch("found", out_ch.found, e.found);
          if (out_ch.out_time !== e.t) report_mismatch("time", out_ch.out_time, e.t);
          if (out_ch.out_x !== e.f1) report_mismatch("x", out_ch.out_x, e.f1);
          if (out_ch.out_y !== e.f2) report_mismatch("y", out_ch.out_y, e.f2);
          if (out_ch.out_heading !== e.f3) report_mismatch("heading", out_ch.out_heading, e.f3);
          if (out_ch.out_curvature !== e.f4)
            report_mismatch("curvature", out_ch.out_curvature, e.f4);
          if (out_ch.out_steer !== e.f5) report_mismatch("steer", out_ch.out_steer, e.f5);
          if (out_ch.out_arc_length !== e.f6)
            report_mismatch("arc_length", out_ch.out_arc_length, e.f6);
          if (out_ch.out_speed !== e.f7) report_mismatch("speed", out_ch.out_speed, e.f7);
          if (out_ch.out_accel !== e.f8) report_mismatch("accel", out_ch.out_accel, e.f8);
        end
      end
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return '0;
      default: return $urandom();
    endcase
  endfunction

  function automatic point_item_t make_item(logic [1:0] k, logic signed [31:0] t);
    point_item_t it;
    it.kind = k; it.t = t;
    it.x = rand_word(); it.y = rand_word(); it.hdg = rand_word(); it.curv = rand_word();
    it.steer = rand_word(); it.arc = rand_word(); it.spd = rand_word(); it.acc = rand_word();
    return it;
  endfunction

  // Wait until the block has drained everything queued so far
  task automatic wait_drained();
    while (pending_items.size() > 0 || in_ch.valid || expected_answers.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_shift(logic [31:0] v);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    m_shift = v;
    @(posedge clk);
  endtask

  // Ask the receiver for a long hold-off and wait until it has started
  task automatic request_stall();
    sink_hold = 1;
    while (long_stall == 0) @(posedge clk);
    sink_hold = 0;
  endtask

  // One trajectory: clear, ragged loads with non-decreasing times, then queries
  task automatic push_trajectory(int npts, int nq, int maxstep);
    logic signed [31:0] t;
    logic signed [31:0] lo_t, hi_t;
    int i;
    pending_items.push_back(make_item(tti_pkg::KIND_CLEAR, $urandom()));
    t = $signed($urandom_range(0, 4000)) - 2000;
    lo_t = t;
    hi_t = t;
    for (i = 0; i < npts; i++) begin
      if ($urandom_range(0, 29) == 0) pending_items.push_back(make_item(KIND_NOP, $urandom()));
      pending_items.push_back(make_item(tti_pkg::KIND_LOAD, t));
      hi_t = t;
      t = t + $urandom_range((i % 7 == 3) ? 0 : 1, maxstep);
    end
    for (i = 0; i < nq; i++) begin
      int r;
      logic signed [31:0] q;
      r = $urandom_range(0, 9);
      if (r == 0) q = lo_t - $urandom_range(1, 50);
      else if (r == 1) q = hi_t + $urandom_range(0, 50);
      else if (r == 2) q = $urandom();
      else q = lo_t + $urandom_range(0, hi_t - lo_t);
      pending_items.push_back(make_item(tti_pkg::KIND_QUERY, q));
    end
  endtask

  int total;
  bit long_done = 0;
  initial begin
    point_item_t it;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty and single-point queries, extremes, ignored kind, base saturation
    write_shift(32'h80000000);
    pending_items.push_back(make_item(tti_pkg::KIND_QUERY, 0));
    pending_items.push_back(make_item(KIND_NOP, 32'hffffffff));
    pending_items.push_back(make_item(tti_pkg::KIND_LOAD, 32'h7fffffff));
    pending_items.push_back(make_item(tti_pkg::KIND_QUERY, 0));
    pending_items.push_back(make_item(tti_pkg::KIND_LOAD, 32'h80000000));
    it = make_item(tti_pkg::KIND_LOAD, 32'h80000000);
    it.arc = 32'h7fffffff;
    pending_items.push_back(it);
    pending_items.push_back(make_item(tti_pkg::KIND_QUERY, 0));
    pending_items.push_back(make_item(tti_pkg::KIND_CLEAR, 0));
    pending_items.push_back(make_item(tti_pkg::KIND_LOAD, 32'h80000000));
    pending_items.push_back(make_item(tti_pkg::KIND_LOAD, 32'h7fffffff));
    pending_items.push_back(make_item(tti_pkg::KIND_QUERY, 0));
    pending_items.push_back(make_item(tti_pkg::KIND_QUERY, 32'hffffffff));
    pending_items.push_back(make_item(tti_pkg::KIND_QUERY, 32'h7fffffff));
    pending_items.push_back(make_item(tti_pkg::KIND_QUERY, 32'h80000000));
    pending_items.push_back(make_item(tti_pkg::KIND_QUERY, 32'h40000000));
    write_shift(32'h7fffffff);
    pending_items.push_back(make_item(tti_pkg::KIND_CLEAR, 0));
    pending_items.push_back(make_item(tti_pkg::KIND_LOAD, 32'h7ffffffe));
    pending_items.push_back(make_item(tti_pkg::KIND_LOAD, 32'h7fffffff));
    pending_items.push_back(make_item(tti_pkg::KIND_LOAD, 32'h7fffffff));
    pending_items.push_back(make_item(tti_pkg::KIND_QUERY, 0));
    pending_items.push_back(make_item(tti_pkg::KIND_QUERY, 1));
    write_shift(32'd1000);

    // random trajectories, occasional full store and shift changes
    total = 0;
    while (total < 1100) begin
      int np, nq;
      np = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 75) : $urandom_range(0, 10);
      nq = $urandom_range(2, 10);
      push_trajectory(np, nq, ($urandom_range(0, 3) == 0) ? 100000 : 300);
      total += np + nq + 1;
      if ($urandom_range(0, 6) == 0) begin
        if ($urandom_range(0, 4) == 0) begin
          // sender pauses until all results are in
          drive_hold = 1;
          while (expected_answers.size() > 0 || in_ch.valid) @(posedge clk);
          drive_hold = 0;
        end else if ($urandom_range(0, 3) == 0) begin
          request_stall();
        end
      end
      if ($urandom_range(0, 24) == 0)
        write_shift($signed($urandom_range(0, 4000)) - 2000);
      while (pending_items.size() > 40) @(posedge clk);
      if (total > 500 && !long_done) begin
        long_done = 1;
        request_stall();
      end
    end
    wait_drained();
    $display("covered %0d loads and %0d queries, %0d of them answered", n_loads, n_queries,
             n_found);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

/* filelist.f */
rtl/tti_pkg.sv
rtl/tti_if.sv
rtl/tti_mem.sv
rtl/tti_div.sv
rtl/trajectory_time_interpolator_top.sv
tb/sv/tb_trajectory_time_interpolator_top.sv
